>>> rtl/round_robin_thread_scheduler_defines.svh
// ----------------------------------------------------------------------------
// Round-robin thread scheduler: assertion macros
// Shared helpers for the concurrent checks, clocked on clk, off during rst.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define RRTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Codes, field layout and table entry type of the round-robin thread scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 4;

  // operations
  localparam logic [2:0] OP_CREATE  = 3'd0;
  localparam logic [2:0] OP_SCHED   = 3'd1;
  localparam logic [2:0] OP_BLOCK   = 3'd2;
  localparam logic [2:0] OP_UNBLOCK = 3'd3;
  localparam logic [2:0] OP_YIELD   = 3'd4;

  // slot status
  localparam logic [2:0] ST_RUN     = 3'd0;
  localparam logic [2:0] ST_READY   = 3'd1;
  localparam logic [2:0] ST_BLOCKED = 3'd2;
  localparam logic [2:0] ST_HANGING = 3'd4;
  localparam logic [2:0] ST_UNUSED  = 3'd5;

  // error codes
  localparam logic [2:0] ERR_OK         = 3'd0;
  localparam logic [2:0] ERR_STATE      = 3'd1;
  localparam logic [2:0] ERR_QUEUED     = 3'd2;
  localparam logic [2:0] ERR_NONE_READY = 3'd3;
  localparam logic [2:0] ERR_KIND       = 3'd4;

  localparam logic [1:0] BK_INVALID = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAIN = 1'b1;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] prio;
  } slot_entry_t;

  function automatic logic is_sleeping(input logic [2:0] s);
    return (s >= ST_BLOCKED) && (s <= ST_HANGING);
  endfunction

endpackage

>>> rtl/round_robin_thread_scheduler.sv
// Flow: an accepted request runs through S_EXEC, then S_PRIO when a scheduling
//   pass pops a slot from the ready deque (extra slot table read), then S_OUT,
//   which registers the result on m_tdata. A new request is taken only after S_OUT,
//   and an output stall holds S_OUT; the read-modify-write on the slot table sets this.
// Reset (rst, synchronous) and any main_slot write reinitialize at once: the
//   slot table is marked invalid by per-slot valid bits, no clearing pass.
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler
// Ready-deque thread scheduler with slot table and deque held in memories.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // operation[2:0], thread_slot[6:3], priority_req[14:7], block_kind[16:15], zero pad
  input  logic [rrts_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // running_slot[3:0], running_prio[11:4], switched[12], new_pid[28:13],
  // error_code[31:29]
  output logic [rrts_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                                cfg_we,
  input  logic [rrts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rrts_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rrts_pkg::*;

  localparam int SW   = $clog2(SLOT_COUNT);
  localparam int CW   = $clog2(SLOT_COUNT + 1);
  localparam int SUMW = CW + 1;
  localparam logic [SW-1:0]   LAST_IDX = SW'(SLOT_COUNT - 1);
  localparam logic [SUMW-1:0] SLOTS_W  = SUMW'(SLOT_COUNT);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_PRIO = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  function automatic logic in_range(input logic [3:0] s);
    return 32'(s) < SLOT_COUNT;
  endfunction

  function automatic logic [SW-1:0] main_eff(input logic [3:0] s);
    return in_range(s) ? SW'(s) : '0;
  endfunction

  state_t            state, state_next;
  logic [3:0]        idle_slot;
  logic [SW-1:0]     cur, cur_next;
  logic [7:0]        cur_prio, cur_prio_next;
  logic [SW-1:0]     head, head_next;
  logic [CW-1:0]     count, count_next;
  logic [15:0]       pid, pid_next;
  logic [SLOT_COUNT-1:0] tbl_vld;

  // latched request
  logic [2:0]        req_op;
  logic [7:0]        req_prio;
  logic [1:0]        req_kind;
  logic [SW-1:0]     req_addr;
  logic              req_ok;

  // results of the pass
  logic [2:0]        res_err, res_err_next;
  logic              res_sw, res_sw_next;
  logic [15:0]       res_pid, res_pid_next;

  // memories
  slot_entry_t       tbl_mem [SLOT_COUNT];
  logic [SW-1:0]     dq_mem  [SLOT_COUNT];
  slot_entry_t       tbl_q, tbl_wdata;
  logic              tbl_vld_q;
  logic              tbl_we;
  logic [SW-1:0]     tbl_waddr, tbl_raddr;
  logic [SW-1:0]     dq_q, dq_wdata, dq_waddr;
  logic              dq_we;

  logic [2:0]        in_op;
  logic [3:0]        in_slot;
  logic [3:0]        in_addr4;
  logic              accept;
  logic              reinit;
  logic [3:0]        reinit_main;
  logic              go_prio;

  logic [SUMW-1:0]   tail_sum;
  logic [SW-1:0]     tail, head_inc, head_dec;
  logic [2:0]        stored_stat;
  logic [7:0]        stored_prio;
  logic              addr_is_cur;

  assign in_op    = s_tdata[2:0];
  assign in_slot  = s_tdata[6:3];
  assign in_addr4 = (in_op == OP_BLOCK) ? idle_slot : in_slot;
  assign s_tready = state[0];
  assign accept   = s_tvalid && s_tready;
  assign reinit   = rst || (cfg_we && (cfg_index == CFG_MAIN));
  assign reinit_main = rst ? 4'd0 : cfg_data;

  assign tail_sum = SUMW'(head) + SUMW'(count);
  assign tail     = (tail_sum >= SLOTS_W) ? SW'(tail_sum - SLOTS_W) : SW'(tail_sum);
  assign head_inc = (head == LAST_IDX) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? LAST_IDX : head - 1'b1;

  // the running slot is tracked in cur; its table entry may be stale, so requests on it are told apart by addr_is_cur
  assign stored_stat = tbl_vld_q ? tbl_q.status : ST_UNUSED;
  assign stored_prio = tbl_vld_q ? tbl_q.prio : 8'd0;
  assign addr_is_cur = (req_addr == cur);

  // first read uses the request address; in S_EXEC it fetches the popped slot
  assign tbl_raddr = state[0] ? SW'(in_addr4) : dq_q;

  // table and deque writes commit only in S_EXEC
  always_ff @(posedge clk) begin
    if (tbl_we && (state == S_EXEC)) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_q     <= tbl_mem[tbl_raddr];
    tbl_vld_q <= tbl_vld[tbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (dq_we && (state == S_EXEC)) begin
      dq_mem[dq_waddr] <= dq_wdata;
    end
    dq_q <= dq_mem[head];
  end

  always_comb begin
    cur_next      = cur;
    cur_prio_next = cur_prio;
    head_next     = head;
    count_next    = count;
    pid_next      = pid;
    res_err_next  = ERR_OK;
    res_sw_next   = 1'b0;
    res_pid_next  = 16'd0;
    tbl_we        = 1'b0;
    tbl_waddr     = cur;
    tbl_wdata     = '{status: ST_READY, prio: cur_prio};
    dq_we         = 1'b0;
    dq_waddr      = tail;
    dq_wdata      = cur;
    go_prio       = 1'b0;
    case (req_op)
      OP_CREATE: begin
        if (!req_ok || addr_is_cur || stored_stat != ST_UNUSED) begin
          res_err_next = ERR_STATE;
        end else begin
          pid_next     = pid + 16'd1;
          res_pid_next = pid + 16'd1;
          tbl_we       = 1'b1;
          tbl_waddr    = req_addr;
          tbl_wdata    = '{status: ST_READY, prio: req_prio};
          dq_we        = 1'b1;
          dq_wdata     = req_addr;
          count_next   = count + 1'b1;
        end
      end
      OP_SCHED, OP_YIELD: begin
        // append current at tail, pop head; empty deque pops current back
        tbl_we      = 1'b1;
        dq_we       = 1'b1;
        head_next   = head_inc;
        res_sw_next = 1'b1;
        if (count != '0) begin
          cur_next = dq_q;
          go_prio  = 1'b1;
        end
      end
      OP_BLOCK: begin
        if (req_kind == BK_INVALID) begin
          res_err_next = ERR_KIND;
        end else if (count != '0) begin
          tbl_we      = 1'b1;
          tbl_wdata   = '{status: ST_BLOCKED + 3'(req_kind), prio: cur_prio};
          head_next   = head_inc;
          count_next  = count - 1'b1;
          cur_next    = dq_q;
          go_prio     = 1'b1;
          res_sw_next = 1'b1;
        end else if (!req_ok || !(addr_is_cur || is_sleeping(stored_stat))) begin
          res_err_next = ERR_NONE_READY;
        end else begin
          // wake the idle slot
          tbl_we        = 1'b1;
          tbl_wdata     = '{status: ST_BLOCKED + 3'(req_kind), prio: cur_prio};
          cur_next      = req_addr;
          cur_prio_next = addr_is_cur ? cur_prio : stored_prio;
          res_sw_next   = 1'b1;
        end
      end
      OP_UNBLOCK: begin
        if (!req_ok || addr_is_cur || !is_sleeping(stored_stat)) begin
          res_err_next = ERR_STATE;
        end else begin
          tbl_we     = 1'b1;
          tbl_waddr  = req_addr;
          tbl_wdata  = '{status: ST_READY, prio: stored_prio};
          dq_we      = 1'b1;
          dq_waddr   = head_dec;
          dq_wdata   = req_addr;
          head_next  = head_dec;
          count_next = count + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_EXEC;
      S_EXEC: state_next = go_prio ? S_PRIO : S_OUT;
      S_PRIO: state_next = S_OUT;
      S_OUT:  if (!m_tvalid || m_tready) state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op   <= in_op;
      req_prio <= s_tdata[14:7];
      req_kind <= s_tdata[16:15];
      req_addr <= SW'(in_addr4);
      req_ok   <= in_range(in_addr4);
    end
    if (state == S_EXEC) begin
      res_err <= res_err_next;
      res_sw  <= res_sw_next;
      res_pid <= res_pid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_slot <= 4'd1;
    end else if (cfg_we && (cfg_index == CFG_IDLE)) begin
      idle_slot <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (reinit) begin
      state    <= S_IDLE;
      cur      <= main_eff(reinit_main);
      cur_prio <= 8'd0;
      head     <= '0;
      count    <= '0;
      pid      <= 16'd0;
      tbl_vld  <= '0;
    end else begin
      state <= state_next;
      if (state == S_EXEC) begin
        cur      <= cur_next;
        cur_prio <= cur_prio_next;
        head     <= head_next;
        count    <= count_next;
        pid      <= pid_next;
        if (tbl_we) begin
          tbl_vld[tbl_waddr] <= 1'b1;
        end
      end
      if (state == S_PRIO) begin
        cur_prio <= stored_prio;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {res_err, res_pid, res_sw, cur_prio, 4'(cur)};
    end
  end

endmodule

>>> rtl/rrts_checker.sv
// ----------------------------------------------------------------------------
// rrts_checker
// Port-level checks of the round-robin thread scheduler, bound to the top.
// ----------------------------------------------------------------------------
`include "round_robin_thread_scheduler_defines.svh"

module rrts_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic [rrts_pkg::IN_TDATA_W-1:0]   s_tdata,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [rrts_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import rrts_pkg::*;

  // one request in flight
  `RRTS_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "request taken while busy")

  // failed requests report no pass and no id
  `RRTS_ASSERT_IMPL(a_err_clean, m_tvalid && (m_tdata[31:29] != ERR_OK), (m_tdata[28:13] == 16'd0) && !m_tdata[12], "error with side result")

  // an id comes only from create, which never switches
  `RRTS_ASSERT_IMPL(a_pid_no_switch, m_tvalid && (m_tdata[28:13] != 16'd0), !m_tdata[12] && (m_tdata[31:29] == ERR_OK), "id with switch or error")

  // stalled result holds
  `RRTS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed")

endmodule

bind round_robin_thread_scheduler rrts_checker u_rrts_checker (.*);
